@@ rtl/ipccsc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipccsc_pkg
// Types, codes and helpers shared by the IPC connection state checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ipccsc_pkg;

  localparam logic [3:0] LastHandleType = 4'd3;
  localparam logic [3:0] HandleTypeConn = 4'd1;

  // item kinds
  localparam logic KindOpen  = 1'b0;
  localparam logic KindEvent = 1'b1;

  // connection states
  localparam logic [3:0] StFree       = 4'd0;
  localparam logic [3:0] StPendConn   = 4'd1;
  localparam logic [3:0] StConnecting = 4'd2;
  localparam logic [3:0] StIdle       = 4'd3;
  localparam logic [3:0] StPendReq    = 4'd4;
  localparam logic [3:0] StActive     = 4'd5;
  localparam logic [3:0] StDisconn    = 4'd6;
  localparam logic [3:0] StError      = 4'd7;
  localparam logic [3:0] StTerminal   = 4'd8;

  // events
  localparam logic [3:0] EvAccept    = 4'd0;
  localparam logic [3:0] EvConnected = 4'd1;
  localparam logic [3:0] EvRequest   = 4'd2;
  localparam logic [3:0] EvActive    = 4'd3;
  localparam logic [3:0] EvReply     = 4'd4;
  localparam logic [3:0] EvClose     = 4'd5;
  localparam logic [3:0] EvClosed    = 4'd6;
  localparam logic [3:0] EvFail      = 4'd7;
  localparam logic [3:0] EvAbort     = 4'd8;

  // status codes
  localparam logic [2:0] RcOk     = 3'd0;
  localparam logic [2:0] RcArg    = 3'd1;
  localparam logic [2:0] RcOwner  = 3'd2;
  localparam logic [2:0] RcHandle = 3'd3;
  localparam logic [2:0] RcState  = 3'd4;

  localparam int unsigned InDataW  = 208;
  localparam int unsigned OutDataW = 8;

  typedef struct packed {
    logic        kind;
    logic [31:0] requester_id;
    logic [31:0] handle_value;
    logic [31:0] handle_generation;
    logic [31:0] handle_owner;
    logic [3:0]  handle_type;
    logic [3:0]  event_req;
    logic        stateless_mode;
    logic [31:0] service_id;
    logic [31:0] service_ver;
  } item_t;

  typedef struct packed {
    logic [3:0]  state;
    logic [31:0] owner;
    logic [31:0] value;
    logic [31:0] generation;
    logic [31:0] handle_owner;
    logic [3:0]  htype;
    logic        stateless;
  } conn_t;

  localparam conn_t ConnReset = '{
    state:        StFree,
    owner:        32'd0,
    value:        32'd0,
    generation:   32'd0,
    handle_owner: 32'd0,
    htype:        4'd0,
    stateless:    1'b0
  };

  function automatic logic handle_ok(logic [31:0] v, logic [31:0] g,
                                     logic [31:0] o, logic [3:0] t);
    return (v != 32'd0) && (g != 32'd0) && (o != 32'd0) && (t != 4'd0) &&
           (t <= LastHandleType);
  endfunction

endpackage

`default_nettype wire

@@ rtl/ipccsc_rules.sv @@
// ----------------------------------------------------------------------------
// ipccsc_rules
// Checks one item (an open on its own fields, an event against the stored
// connection) and computes status and the connection record after the item.
// ----------------------------------------------------------------------------
`default_nettype none

module ipccsc_rules import ipccsc_pkg::*; (
  input  item_t      item_i,
  input  conn_t      conn_i,
  output logic [2:0] status_o,
  output conn_t      conn_o
);

  logic  open_bad;
  logic  ev_arg_bad;
  logic  ev_owner_bad;
  logic  ev_handle_bad;
  logic  rule_bad;
  logic  [3:0] rule_next;
  conn_t opened;

  assign open_bad = (item_i.requester_id == 32'd0) || (item_i.service_id == 32'd0) ||
                    (item_i.service_ver == 32'd0) ||
                    (item_i.handle_type != HandleTypeConn) ||
                    (item_i.handle_owner != item_i.requester_id) ||
                    !handle_ok(item_i.handle_value, item_i.handle_generation,
                               item_i.handle_owner, item_i.handle_type);

  assign ev_arg_bad   = (item_i.requester_id == 32'd0) || (item_i.event_req > EvAbort) ||
                        (conn_i.state > StTerminal);
  assign ev_owner_bad = item_i.requester_id != conn_i.owner;
  assign ev_handle_bad =
      !handle_ok(conn_i.value, conn_i.generation, conn_i.handle_owner, conn_i.htype) ||
      !handle_ok(item_i.handle_value, item_i.handle_generation,
                 item_i.handle_owner, item_i.handle_type) ||
      (item_i.handle_value != conn_i.value) ||
      (item_i.handle_generation != conn_i.generation) ||
      (item_i.handle_owner != conn_i.handle_owner) ||
      (item_i.handle_type != conn_i.htype);

  always_comb begin
    opened = '{
      state:        item_i.stateless_mode ? StIdle : StPendConn,
      owner:        item_i.requester_id,
      value:        item_i.handle_value,
      generation:   item_i.handle_generation,
      handle_owner: item_i.handle_owner,
      htype:        item_i.handle_type,
      stateless:    item_i.stateless_mode
    };
  end

  // transition table; close-complete is handled by the status block below
  always_comb begin
    rule_bad  = 1'b0;
    rule_next = conn_i.state;
    unique case (item_i.event_req)
      EvAccept: begin
        rule_bad  = conn_i.stateless || (conn_i.state != StPendConn);
        rule_next = StConnecting;
      end
      EvConnected: begin
        rule_bad  = conn_i.stateless || (conn_i.state != StConnecting);
        rule_next = StIdle;
      end
      EvRequest: begin
        rule_bad  = conn_i.state != StIdle;
        rule_next = StPendReq;
      end
      EvActive: begin
        rule_bad  = conn_i.state != StPendReq;
        rule_next = StActive;
      end
      EvReply: begin
        rule_bad  = conn_i.state != StActive;
        rule_next = StIdle;
      end
      EvClose: begin
        rule_bad  = conn_i.stateless || (conn_i.state != StIdle);
        rule_next = StDisconn;
      end
      EvClosed: begin
        rule_bad  = conn_i.state != StDisconn;
        rule_next = StFree;
      end
      EvFail: begin
        rule_bad  = (conn_i.state == StFree) || (conn_i.state == StTerminal);
        rule_next = StError;
      end
      default: begin
        rule_bad  = (conn_i.state == StFree) || (conn_i.state == StTerminal);
        rule_next = StTerminal;
      end
    endcase
  end

  always_comb begin
    conn_o   = conn_i;
    status_o = RcOk;
    if (item_i.kind == KindOpen) begin
      if (open_bad) begin
        status_o = RcArg;
      end else begin
        conn_o = opened;
      end
    end else begin
      priority if (ev_arg_bad) begin
        status_o = RcArg;
      end else if (ev_owner_bad) begin
        status_o = RcOwner;
      end else if (ev_handle_bad) begin
        status_o = RcHandle;
      end else if (rule_bad) begin
        status_o = RcState;
      end else if (item_i.event_req == EvClosed) begin
        conn_o = ConnReset;
      end else begin
        conn_o.state = rule_next;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ipc_connection_state_checker_unit.sv @@
// ----------------------------------------------------------------------------
// ipc_connection_state_checker_unit
// Guards one IPC connection: open transactions are checked on their own fields
// and event transactions against the stored owner and handle; each returns a status and the new state.
//
//   channel  dir  tdata                      tuser
//   s_axis   in   item fields, 208 bits      kind
//   m_axis   out  status, conn_state, 8 bit  -
//
// One transaction per cycle sustained while the result is not stalled; the result
// passes through the input register, then the result register.
// The connection record updates as the item leaves the input register, so
// the next item sees it with no bubble.
// A stalled result holds the input register; input ready drops only then.
// Reset clears the connection to free with a zero owner and handle.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_connection_state_checker_unit import ipccsc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // requester_id, handle_value, handle_generation, handle_owner, handle_type,
  // event_req, stateless_mode, service_id, service_ver, zero pad
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // kind
  input  wire logic [0:0]          s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // status, conn_state, zero pad
  output logic [OutDataW-1:0]      m_axis_tdata
);

  item_t      item_d;
  item_t      item_q;
  logic       in_valid_q;
  logic       out_valid_q;
  logic [2:0] status_q;
  logic [3:0] state_out_q;
  conn_t      conn_q;
  conn_t      conn_d;
  logic [2:0] status_d;
  logic       out_free;
  logic       advance;
  logic       in_take;

  assign item_d = '{
    kind:              s_axis_tuser[0],
    requester_id:      s_axis_tdata[31:0],
    handle_value:      s_axis_tdata[63:32],
    handle_generation: s_axis_tdata[95:64],
    handle_owner:      s_axis_tdata[127:96],
    handle_type:       s_axis_tdata[131:128],
    event_req:         s_axis_tdata[135:132],
    stateless_mode:    s_axis_tdata[136],
    service_id:        s_axis_tdata[168:137],
    service_ver:       s_axis_tdata[200:169]
  };

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  ipccsc_rules u_rules (
    .item_i   (item_q),
    .conn_i   (conn_q),
    .status_o (status_d),
    .conn_o   (conn_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      conn_q      <= ConnReset;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        conn_q      <= conn_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= item_d;
    end
    if (advance) begin
      status_q    <= status_d;
      state_out_q <= conn_d.state;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, state_out_q, status_q};

  // input only backs up behind a stalled result
  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a stalled result");

  // a free connection carries no owner and no handle
  a_free_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (conn_q.state == StFree) |-> (conn_q.owner == 32'd0 && conn_q.htype == 4'd0))
    else $error("free connection keeps owner or handle");

  // a rejected item leaves the connection untouched
  a_reject_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && status_d != RcOk) |=> (conn_q == $past(conn_q)))
    else $error("rejected item changed the connection");

  a_state_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    conn_q.state <= StTerminal)
    else $error("connection state out of range");

endmodule

`default_nettype wire
